// File: rtl/core/orec_pkg.sv
// ============================================================================
// orec_pkg
// Shared types, constants and the sequencer program of the ordered record table.
// ============================================================================
`default_nettype none

package orec_pkg;

    // Field widths of one transaction on either channel.
    localparam int KEY_W          = 32;
    localparam int AGE_W          = 8;
    localparam int NAME_WORD_W    = 64;
    localparam int NAME_LAST_W    = 48;
    localparam int NAME_ALL_W     = 3 * NAME_WORD_W + NAME_LAST_W;
    localparam int NAME_MAX_BYTES = NAME_ALL_W / 8;
    localparam int STATUS_W       = 3;
    localparam int OP_W           = 2;

    // Default configuration.
    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_NAME_BYTES  = 30;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2,
        OP_LIST   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    // Datapath action of one control word.
    typedef enum logic [3:0] {
        A_NONE,
        A_ACCEPT,
        A_CLR_IDX,
        A_INC_IDX,
        A_READ,
        A_READ_NEXT,
        A_WRITE_NEW,
        A_SHIFT,
        A_DEC,
        A_EMIT
    } t_act;

    // Branch condition of one control word.
    typedef enum logic [2:0] {
        C_NEXT,
        C_GOTO,
        C_DISPATCH,
        C_FULL,
        C_IDX_END,
        C_NEXT_END,
        C_MATCH,
        C_ZERO
    } t_cond;

    typedef enum logic {
        L_ONE,
        L_LIST
    } t_last;

    typedef logic [4:0] t_step;

    typedef struct packed {
        t_act    act;
        t_cond   cond;
        t_step   target;
        t_status status;
        logic    with_data;
        t_last   last;
    } t_uop;

    // Program addresses.
    localparam t_step S_FETCH    = 5'd0;
    localparam t_step S_INS      = 5'd1;
    localparam t_step S_INS_WR   = 5'd2;
    localparam t_step S_DONE     = 5'd3;
    localparam t_step S_FULL     = 5'd4;
    localparam t_step S_SRCH     = 5'd5;
    localparam t_step S_SRCH_TST = 5'd6;
    localparam t_step S_SRCH_RD  = 5'd7;
    localparam t_step S_SRCH_CMP = 5'd8;
    localparam t_step S_SRCH_INC = 5'd9;
    localparam t_step S_MISS     = 5'd10;
    localparam t_step S_HIT      = 5'd11;
    localparam t_step S_REM      = 5'd12;
    localparam t_step S_REM_TST  = 5'd13;
    localparam t_step S_REM_RD   = 5'd14;
    localparam t_step S_REM_CMP  = 5'd15;
    localparam t_step S_REM_INC  = 5'd16;
    localparam t_step S_SHF_TST  = 5'd17;
    localparam t_step S_SHF_RD   = 5'd18;
    localparam t_step S_SHF_WR   = 5'd19;
    localparam t_step S_REM_DEC  = 5'd20;
    localparam t_step S_LIST     = 5'd21;
    localparam t_step S_LST_RD   = 5'd22;
    localparam t_step S_LST_EMIT = 5'd23;
    localparam t_step S_LST_INC  = 5'd24;
    localparam t_step S_LST_LOOP = 5'd25;
    localparam t_step S_EMPTY    = 5'd26;

    function automatic t_uop mk_uop(t_act act, t_cond cond, t_step target,
                                    t_status status, logic with_data, t_last last);
        t_uop u;
        u.act       = act;
        u.cond      = cond;
        u.target    = target;
        u.status    = status;
        u.with_data = with_data;
        u.last      = last;
        return u;
    endfunction

    // The control program, one word per step.
    function automatic t_uop ucode_rom(t_step step);
        t_uop u;
        u = mk_uop(A_NONE, C_GOTO, S_FETCH, ST_DONE, 1'b0, L_ONE);
        unique case (step)
            S_FETCH:    u = mk_uop(A_ACCEPT, C_DISPATCH, S_FETCH, ST_DONE, 1'b0, L_ONE);
            S_INS:      u = mk_uop(A_NONE, C_FULL, S_FULL, ST_DONE, 1'b0, L_ONE);
            S_INS_WR:   u = mk_uop(A_WRITE_NEW, C_GOTO, S_DONE, ST_DONE, 1'b0, L_ONE);
            S_DONE:     u = mk_uop(A_EMIT, C_GOTO, S_FETCH, ST_DONE, 1'b0, L_ONE);
            S_FULL:     u = mk_uop(A_EMIT, C_GOTO, S_FETCH, ST_FULL, 1'b0, L_ONE);
            S_SRCH:     u = mk_uop(A_CLR_IDX, C_NEXT, S_FETCH, ST_DONE, 1'b0, L_ONE);
            S_SRCH_TST: u = mk_uop(A_NONE, C_IDX_END, S_MISS, ST_DONE, 1'b0, L_ONE);
            S_SRCH_RD:  u = mk_uop(A_READ, C_NEXT, S_FETCH, ST_DONE, 1'b0, L_ONE);
            S_SRCH_CMP: u = mk_uop(A_NONE, C_MATCH, S_HIT, ST_DONE, 1'b0, L_ONE);
            S_SRCH_INC: u = mk_uop(A_INC_IDX, C_GOTO, S_SRCH_TST, ST_DONE, 1'b0, L_ONE);
            S_MISS:     u = mk_uop(A_EMIT, C_GOTO, S_FETCH, ST_NOT_FOUND, 1'b0, L_ONE);
            S_HIT:      u = mk_uop(A_EMIT, C_GOTO, S_FETCH, ST_FOUND, 1'b1, L_ONE);
            S_REM:      u = mk_uop(A_CLR_IDX, C_NEXT, S_FETCH, ST_DONE, 1'b0, L_ONE);
            S_REM_TST:  u = mk_uop(A_NONE, C_IDX_END, S_MISS, ST_DONE, 1'b0, L_ONE);
            S_REM_RD:   u = mk_uop(A_READ, C_NEXT, S_FETCH, ST_DONE, 1'b0, L_ONE);
            S_REM_CMP:  u = mk_uop(A_NONE, C_MATCH, S_SHF_TST, ST_DONE, 1'b0, L_ONE);
            S_REM_INC:  u = mk_uop(A_INC_IDX, C_GOTO, S_REM_TST, ST_DONE, 1'b0, L_ONE);
            S_SHF_TST:  u = mk_uop(A_NONE, C_NEXT_END, S_REM_DEC, ST_DONE, 1'b0, L_ONE);
            S_SHF_RD:   u = mk_uop(A_READ_NEXT, C_NEXT, S_FETCH, ST_DONE, 1'b0, L_ONE);
            S_SHF_WR:   u = mk_uop(A_SHIFT, C_GOTO, S_SHF_TST, ST_DONE, 1'b0, L_ONE);
            S_REM_DEC:  u = mk_uop(A_DEC, C_GOTO, S_DONE, ST_DONE, 1'b0, L_ONE);
            S_LIST:     u = mk_uop(A_CLR_IDX, C_ZERO, S_EMPTY, ST_DONE, 1'b0, L_ONE);
            S_LST_RD:   u = mk_uop(A_READ, C_NEXT, S_FETCH, ST_DONE, 1'b0, L_ONE);
            S_LST_EMIT: u = mk_uop(A_EMIT, C_NEXT, S_FETCH, ST_FOUND, 1'b1, L_LIST);
            S_LST_INC:  u = mk_uop(A_INC_IDX, C_NEXT_END, S_FETCH, ST_DONE, 1'b0, L_ONE);
            S_LST_LOOP: u = mk_uop(A_NONE, C_GOTO, S_LST_RD, ST_DONE, 1'b0, L_ONE);
            S_EMPTY:    u = mk_uop(A_EMIT, C_GOTO, S_FETCH, ST_EMPTY, 1'b0, L_ONE);
            default:    u = mk_uop(A_NONE, C_GOTO, S_FETCH, ST_DONE, 1'b0, L_ONE);
        endcase
        return u;
    endfunction

    // Entry point of each operation's routine.
    function automatic t_step dispatch(t_op op);
        t_step s;
        unique case (op)
            OP_INSERT: s = S_INS;
            OP_SEARCH: s = S_SRCH;
            OP_REMOVE: s = S_REM;
            OP_LIST:   s = S_LIST;
            default:   s = S_FETCH;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/orec_if.sv
// ============================================================================
// orec_if
// Request and response channels of the ordered record table.
// ============================================================================
`default_nettype none

interface orec_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [orec_pkg::OP_W-1:0]              operation;
    logic signed [orec_pkg::KEY_W-1:0]      record_key;
    logic [orec_pkg::AGE_W-1:0]             record_age;
    logic [orec_pkg::NAME_WORD_W-1:0]       name_word0;
    logic [orec_pkg::NAME_WORD_W-1:0]       name_word1;
    logic [orec_pkg::NAME_WORD_W-1:0]       name_word2;
    logic [orec_pkg::NAME_LAST_W-1:0]       name_word3;

    modport source (
        output valid, operation, record_key, record_age,
        output name_word0, name_word1, name_word2, name_word3,
        input  ready
    );
    modport sink (
        input  valid, operation, record_key, record_age,
        input  name_word0, name_word1, name_word2, name_word3,
        output ready
    );
endinterface

interface orec_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic [orec_pkg::STATUS_W-1:0]          status;
    logic signed [orec_pkg::KEY_W-1:0]      out_key;
    logic [orec_pkg::AGE_W-1:0]             out_age;
    logic [orec_pkg::NAME_WORD_W-1:0]       out_name0;
    logic [orec_pkg::NAME_WORD_W-1:0]       out_name1;
    logic [orec_pkg::NAME_WORD_W-1:0]       out_name2;
    logic [orec_pkg::NAME_LAST_W-1:0]       out_name3;
    logic                                   last_item;

    modport source (
        output valid, status, out_key, out_age,
        output out_name0, out_name1, out_name2, out_name3, last_item,
        input  ready
    );
    modport sink (
        input  valid, status, out_key, out_age,
        input  out_name0, out_name1, out_name2, out_name3, last_item,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/orec_ram.sv
// ============================================================================
// orec_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module orec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ordered_record_table.sv
// ============================================================================
// ordered_record_table
// Bounded, insertion-ordered record table run by a microcoded sequencer.
// ============================================================================
// The table holds up to TABLE_DEPTH records (key, age, name) in the order in
// which they were inserted, packed from entry zero upward in one RAM whose
// read data is registered. A request transaction carries one operation:
// insert appends a record at the end or answers "table full"; search
// answers with the first record whose key matches or "not found"; remove
// deletes the first match and moves every later record down one place, or
// answers "not found"; list returns every record in order, with last_item
// set on the final one, or a single "table empty" response. Every other
// operation gives exactly one response, with last_item set. Name bytes at
// and beyond NAME_BYTES are neither stored nor returned; they read as zero.
// One request is handled at a time. An insert checks for a full table,
// then writes the record. Search and remove walk the table through the
// single RAM read port, one entry after another, and a remove then moves
// each later record down with a read and a write and lowers the count.
// A list emits each record in turn. The response register lets the next
// request be accepted while the last response is still waiting to be
// taken; a response that is not taken stalls the sequencer at its emit step.
// No clearing pass follows reset: entries are read only once written.
// ============================================================================
`default_nettype none

module ordered_record_table #(
    parameter int TABLE_DEPTH = orec_pkg::DEF_TABLE_DEPTH,
    parameter int NAME_BYTES  = orec_pkg::DEF_NAME_BYTES
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    orec_req_if.sink    i_req,
    orec_rsp_if.source  o_rsp
);

    import orec_pkg::*;

    // Address width of the table, and count width that can also hold the
    // full-table value.
    localparam int AW         = $clog2(TABLE_DEPTH);
    localparam int CW         = $clog2(TABLE_DEPTH + 1);
    localparam int NAME_KEEP  = (NAME_BYTES < NAME_MAX_BYTES) ? NAME_BYTES : NAME_MAX_BYTES;
    localparam int NAME_W     = 8 * NAME_KEEP;
    localparam int REC_W      = KEY_W + AGE_W + NAME_W;

    // Sequencer state.
    t_step r_step;
    t_step n_step;
    t_uop  w_uop;

    // Table bookkeeping.
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [CW:0]   w_idx_p1;

    // Latched request.
    logic [KEY_W-1:0]   r_key;
    logic [AGE_W-1:0]   r_age;
    logic [NAME_W-1:0]  r_name;
    logic [NAME_ALL_W-1:0] w_in_name;

    // RAM port.
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [REC_W-1:0]  w_wdata;
    logic              w_re;
    logic [AW-1:0]     w_raddr;
    logic [REC_W-1:0]  w_rdata;

    // Fields of the record last read.
    logic [KEY_W-1:0]      w_rec_key;
    logic [AGE_W-1:0]      w_rec_age;
    logic [NAME_ALL_W-1:0] w_rec_name;

    // Branch conditions and handshake qualifiers.
    logic w_full;
    logic w_idx_end;
    logic w_next_end;
    logic w_match;
    logic w_zero;
    logic w_out_free;
    logic w_accept;
    logic w_emit;
    logic w_stall;
    logic w_taken;

    // Response register.
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [KEY_W-1:0]      r_out_key;
    logic [AGE_W-1:0]      r_out_age;
    logic [NAME_ALL_W-1:0] r_out_name;
    logic                  r_out_last;

    assign w_uop      = ucode_rom(r_step);
    assign w_in_name  = {i_req.name_word3, i_req.name_word2, i_req.name_word1,
                         i_req.name_word0};

    assign w_rec_key  = w_rdata[KEY_W-1:0];
    assign w_rec_age  = w_rdata[KEY_W+AGE_W-1:KEY_W];
    assign w_rec_name = NAME_ALL_W'(w_rdata[REC_W-1:KEY_W+AGE_W]);

    assign w_idx_p1   = {1'b0, r_idx} + (CW+1)'(1);
    assign w_full     = (r_count == CW'(TABLE_DEPTH));
    assign w_idx_end  = (r_idx == r_count);
    assign w_next_end = (w_idx_p1 >= {1'b0, r_count});
    assign w_match    = (w_rec_key == r_key);
    assign w_zero     = (r_count == '0);

    // The response slot is free when empty or being taken in this cycle.
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_taken    = r_out_valid && o_rsp.ready;

    assign i_req.ready = i_rst_n && (w_uop.act == A_ACCEPT);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_emit      = (w_uop.act == A_EMIT) && w_out_free;

    // A step holds while its handshake partner is not there.
    assign w_stall = ((w_uop.act == A_ACCEPT) && !i_req.valid)
                  || ((w_uop.act == A_EMIT) && !w_out_free);

    // Next step: stay, fall through, or branch on the selected condition.
    always_comb begin
        n_step = r_step;
        if (!w_stall) begin
            unique case (w_uop.cond)
                C_NEXT:     n_step = r_step + t_step'(1);
                C_GOTO:     n_step = w_uop.target;
                C_DISPATCH: n_step = dispatch(t_op'(i_req.operation));
                C_FULL:     n_step = w_full ? w_uop.target : r_step + t_step'(1);
                C_IDX_END:  n_step = w_idx_end ? w_uop.target : r_step + t_step'(1);
                C_NEXT_END: n_step = w_next_end ? w_uop.target : r_step + t_step'(1);
                C_MATCH:    n_step = w_match ? w_uop.target : r_step + t_step'(1);
                C_ZERO:     n_step = w_zero ? w_uop.target : r_step + t_step'(1);
                default:    n_step = S_FETCH;
            endcase
        end
    end

    // RAM controls decoded from the current control word.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = w_rdata;
        w_re    = 1'b0;
        w_raddr = r_idx[AW-1:0];
        unique case (w_uop.act)
            A_READ: begin
                w_re = 1'b1;
            end
            A_READ_NEXT: begin
                w_re    = 1'b1;
                w_raddr = w_idx_p1[AW-1:0];
            end
            A_WRITE_NEW: begin
                w_we    = 1'b1;
                w_waddr = r_count[AW-1:0];
                w_wdata = {r_name, r_age, r_key};
            end
            A_SHIFT: begin
                // Move the record above the gap one place down.
                w_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            priority case (w_uop.act)
                A_WRITE_NEW: r_count <= r_count + CW'(1);
                A_DEC:       r_count <= r_count - CW'(1);
                default:     r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        priority case (w_uop.act)
            A_CLR_IDX:          r_idx <= '0;
            A_INC_IDX, A_SHIFT: r_idx <= w_idx_p1[CW-1:0];
            default:            r_idx <= r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key  <= i_req.record_key;
            r_age  <= i_req.record_age;
            r_name <= w_in_name[NAME_W-1:0];
        end
    end

    // Response register: loaded by an emit step, freed when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (w_taken) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_status <= w_uop.status;
            r_out_key    <= w_uop.with_data ? w_rec_key  : '0;
            r_out_age    <= w_uop.with_data ? w_rec_age  : '0;
            r_out_name   <= w_uop.with_data ? w_rec_name : '0;
            r_out_last   <= (w_uop.last == L_ONE) || (w_idx_p1 == {1'b0, r_count});
        end
    end

    orec_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.out_key   = r_out_key;
    assign o_rsp.out_age   = r_out_age;
    assign o_rsp.out_name0 = r_out_name[NAME_WORD_W-1:0];
    assign o_rsp.out_name1 = r_out_name[2*NAME_WORD_W-1:NAME_WORD_W];
    assign o_rsp.out_name2 = r_out_name[3*NAME_WORD_W-1:2*NAME_WORD_W];
    assign o_rsp.out_name3 = r_out_name[NAME_ALL_W-1:3*NAME_WORD_W];
    assign o_rsp.last_item = r_out_last;

endmodule

`default_nettype wire

// File: rtl/core/orec_checker.sv
// ============================================================================
// orec_checker
// Port-level checks of the ordered record table, bound to its top level.
// ============================================================================
`default_nettype none

module orec_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_req_valid,
    input wire logic                           i_req_ready,
    input wire logic                           i_rsp_valid,
    input wire logic                           i_rsp_ready,
    input wire logic [orec_pkg::STATUS_W-1:0]  i_status,
    input wire logic [orec_pkg::KEY_W-1:0]     i_key,
    input wire logic [orec_pkg::AGE_W-1:0]     i_age,
    input wire logic                           i_last
);

    import orec_pkg::*;

    // A pending response holds until it is taken.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status) && $stable(i_key))
        else $error("response changed while stalled");

    // Requests are handled one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted in two consecutive cycles");

    // Only known status codes leave the block.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_status == ST_DONE) || (i_status == ST_FOUND)
                     || (i_status == ST_NOT_FOUND) || (i_status == ST_FULL)
                     || (i_status == ST_EMPTY))
        else $error("unknown status code");

    // A response without a record carries zero data and is the only one.
    a_plain_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status != ST_FOUND) |-> (i_key == '0) && (i_age == '0) && i_last)
        else $error("status-only response carries data or misses last mark");

endmodule

bind ordered_record_table orec_checker u_orec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_key       (o_rsp.out_key),
    .i_age       (o_rsp.out_age),
    .i_last      (o_rsp.last_item)
);

`default_nettype wire
